FILE: design/ccns_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ccns_pkg;

    localparam int CNT_W       = 64;
    localparam int FREQ_W      = 34;
    localparam int NS_W        = 30;
    localparam int FRAC_STEPS  = 30;
    localparam int WHOLE_STEPS = 64;

    localparam logic [NS_W-1:0] NS_PER_SEC = 30'd1000000000;

    localparam logic CFG_FREQ   = 1'b0;
    localparam logic CFG_OFFSET = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_CAL   = 2'd1,
        ST_BEFORE    = 2'd2
    } status_t;

    typedef struct packed {
        logic    vld;
        status_t st;
    } ccns_ctl_t;

endpackage
`default_nettype wire

FILE: design/ccns_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ccns_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] counter_value;
    modport source (output valid, output counter_value, input ready);
    modport sink (input valid, input counter_value, output ready);
endinterface

interface ccns_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] time_ns;
    logic [1:0]  status;
    modport source (output valid, output time_ns, output status, input ready);
    modport sink (input valid, input time_ns, input status, output ready);
endinterface

interface ccns_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [63:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: design/ccns_front.sv
`timescale 1ns / 1ps
`default_nettype none
module ccns_front
    import ccns_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              in_vld,
    input  wire logic [CNT_W-1:0]  in_value,
    input  wire logic [FREQ_W-1:0] freq,
    input  wire logic [CNT_W-1:0]  offset,
    output ccns_ctl_t              ctl,
    output logic [CNT_W-1:0]       whole,
    output logic [FREQ_W-1:0]      part
);

    logic              vld_reg  [0:WHOLE_STEPS];
    status_t           st_reg   [0:WHOLE_STEPS];
    logic [FREQ_W-1:0] rem_reg  [0:WHOLE_STEPS];
    logic [CNT_W-1:0]  work_reg [0:WHOLE_STEPS];

    logic [CNT_W:0] diff;
    status_t        st_next;

    always_comb
    begin
        diff = {1'b0, in_value} - {1'b0, offset};
        if (freq == '0)
            st_next = ST_NOT_CAL;
        else if (diff[CNT_W])
            st_next = ST_BEFORE;
        else
            st_next = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (adv)
            vld_reg[0] <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0]   <= st_next;
            rem_reg[0]  <= '0;
            work_reg[0] <= diff[CNT_W-1:0];
        end
    end

    for (genvar i = 0; i < WHOLE_STEPS; i++)
    begin : g_step
        logic [FREQ_W:0]   trial;
        logic [FREQ_W:0]   sub;
        logic              take;

        always_comb
        begin
            trial = {rem_reg[i], work_reg[i][CNT_W-1]};
            sub   = trial - {1'b0, freq};
            take  = trial >= {1'b0, freq};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i+1] <= 1'b0;
            else if (adv)
                vld_reg[i+1] <= vld_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_reg[i+1]   <= st_reg[i];
                rem_reg[i+1]  <= take ? sub[FREQ_W-1:0] : trial[FREQ_W-1:0];
                work_reg[i+1] <= {work_reg[i][CNT_W-2:0], take};
            end
        end
    end

    assign ctl.vld = vld_reg[WHOLE_STEPS];
    assign ctl.st  = st_reg[WHOLE_STEPS];
    assign whole   = work_reg[WHOLE_STEPS];
    assign part    = rem_reg[WHOLE_STEPS];

endmodule
`default_nettype wire

FILE: design/ccns_scale.sv
`timescale 1ns / 1ps
`default_nettype none
module ccns_scale
    import ccns_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  ccns_ctl_t              ctl_in,
    input  wire logic [CNT_W-1:0]  whole,
    input  wire logic [FREQ_W-1:0] part,
    output ccns_ctl_t              ctl_out,
    output logic [CNT_W-1:0]       acc,
    output logic [CNT_W-1:0]       dividend
);

    logic             v1_reg, v2_reg, v3_reg;
    status_t          s1_reg, s2_reg, s3_reg;
    logic [CNT_W-1:0] pp1_reg, pp2_reg, pp3_reg;
    logic [CNT_W-1:0] whole1_reg;
    logic [31:0]      hi2_reg;
    logic [CNT_W-1:0] lo2_reg;
    logic [CNT_W-1:0] acc3_reg;
    logic [CNT_W-1:0] hi_prod;

    always_comb
    begin
        hi_prod = {32'b0, hi2_reg} * {34'b0, NS_PER_SEC};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= ctl_in.vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg     <= ctl_in.st;
            pp1_reg    <= {30'b0, part} * {34'b0, NS_PER_SEC};
            whole1_reg <= whole;
            s2_reg     <= s1_reg;
            pp2_reg    <= pp1_reg;
            hi2_reg    <= whole1_reg[63:32];
            lo2_reg    <= {32'b0, whole1_reg[31:0]} * {34'b0, NS_PER_SEC};
            s3_reg     <= s2_reg;
            pp3_reg    <= pp2_reg;
            acc3_reg   <= lo2_reg + {hi_prod[31:0], 32'b0};
        end
    end

    assign ctl_out  = '{vld: v3_reg, st: s3_reg};
    assign acc      = acc3_reg;
    assign dividend = pp3_reg;

endmodule
`default_nettype wire

FILE: design/ccns_frac_div.sv
`timescale 1ns / 1ps
`default_nettype none
module ccns_frac_div
    import ccns_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic [FREQ_W-1:0] freq,
    input  ccns_ctl_t              ctl_in,
    input  wire logic [CNT_W-1:0]  acc_in,
    input  wire logic [CNT_W-1:0]  dividend,
    output ccns_ctl_t              ctl_out,
    output logic [CNT_W-1:0]       acc_out,
    output logic [NS_W-1:0]        quot
);

    logic              vld_reg  [0:FRAC_STEPS];
    status_t           st_reg   [0:FRAC_STEPS];
    logic [CNT_W-1:0]  acc_reg  [0:FRAC_STEPS];
    logic [FREQ_W-1:0] rem_reg  [0:FRAC_STEPS];
    logic [NS_W-1:0]   work_reg [0:FRAC_STEPS];

    always_comb
    begin
        vld_reg[0]  = ctl_in.vld;
        st_reg[0]   = ctl_in.st;
        acc_reg[0]  = acc_in;
        rem_reg[0]  = dividend[CNT_W-1:NS_W];
        work_reg[0] = dividend[NS_W-1:0];
    end

    for (genvar i = 0; i < FRAC_STEPS; i++)
    begin : g_step
        logic [FREQ_W:0] trial;
        logic [FREQ_W:0] sub;
        logic            take;

        always_comb
        begin
            trial = {rem_reg[i], work_reg[i][NS_W-1]};
            sub   = trial - {1'b0, freq};
            take  = trial >= {1'b0, freq};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i+1] <= 1'b0;
            else if (adv)
                vld_reg[i+1] <= vld_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_reg[i+1]   <= st_reg[i];
                acc_reg[i+1]  <= acc_reg[i];
                rem_reg[i+1]  <= take ? sub[FREQ_W-1:0] : trial[FREQ_W-1:0];
                work_reg[i+1] <= {work_reg[i][NS_W-2:0], take};
            end
        end
    end

    assign ctl_out.vld = vld_reg[FRAC_STEPS];
    assign ctl_out.st  = st_reg[FRAC_STEPS];
    assign acc_out     = acc_reg[FRAC_STEPS];
    assign quot        = work_reg[FRAC_STEPS];

endmodule
`default_nettype wire

FILE: design/cycle_count_to_nanoseconds_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Converts a 64-bit cycle counter reading into nanoseconds since the boot
// offset. One reading enters every cycle unless the result side stalls, and
// it passes 99 register stages (1 subtract stage, 64 stages of the seconds
// divider at one quotient bit each, 3 multiply stages, 30 stages of the
// fraction divider, 1 output stage).
// A stall on the result side holds the whole pipeline. Register 0
// is the counter frequency in hertz (bits above 33 dropped), register 1 the
// boot offset; write them only while no reading is in flight. Status 1 means
// frequency zero, status 2 a reading below the offset; time_ns is then 0.
module cycle_count_to_nanoseconds_unit
    import ccns_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    ccns_cfg_if.sink   cfg,
    ccns_in_if.sink    sample,
    ccns_out_if.source result
);

    logic [FREQ_W-1:0] freq_reg;
    logic [CNT_W-1:0]  offset_reg;
    logic              adv;

    ccns_ctl_t         front_ctl, scale_ctl, frac_ctl;
    logic [CNT_W-1:0]  whole, acc, dividend, frac_acc;
    logic [FREQ_W-1:0] part;
    logic [NS_W-1:0]   quot;

    logic              out_vld_reg;
    logic [CNT_W-1:0]  out_time_reg;
    status_t           out_st_reg;

    assign cfg.ready    = 1'b1;
    assign adv          = !out_vld_reg || result.ready;
    assign sample.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg   <= '0;
            offset_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_FREQ:   freq_reg   <= cfg.data[FREQ_W-1:0];
                CFG_OFFSET: offset_reg <= cfg.data;
                default:    ;
            endcase
        end
    end

    ccns_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (sample.valid),
        .in_value (sample.counter_value),
        .freq     (freq_reg),
        .offset   (offset_reg),
        .ctl      (front_ctl),
        .whole    (whole),
        .part     (part)
    );

    ccns_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .ctl_in   (front_ctl),
        .whole    (whole),
        .part     (part),
        .ctl_out  (scale_ctl),
        .acc      (acc),
        .dividend (dividend)
    );

    ccns_frac_div u_frac (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .freq     (freq_reg),
        .ctl_in   (scale_ctl),
        .acc_in   (acc),
        .dividend (dividend),
        .ctl_out  (frac_ctl),
        .acc_out  (frac_acc),
        .quot     (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= frac_ctl.vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_st_reg   <= frac_ctl.st;
            out_time_reg <= (frac_ctl.st == ST_OK) ? frac_acc + {34'b0, quot} : '0;
        end
    end

    assign result.valid   = out_vld_reg;
    assign result.time_ns = out_time_reg;
    assign result.status  = out_st_reg;

endmodule
`default_nettype wire

FILE: design/ccns_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module ccns_props
    import ccns_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [63:0] out_time_ns,
    input wire logic [1:0]  out_status
);

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_status == ST_OK || out_status == ST_NOT_CAL ||
                       out_status == ST_BEFORE))
        else $error("status code out of range");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_status != ST_OK) |-> out_time_ns == '0)
        else $error("nonzero time on error status");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while pipeline stalled");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_time_ns) &&
                                       $stable(out_status)))
        else $error("stalled result changed");

endmodule

bind cycle_count_to_nanoseconds_unit ccns_props u_props (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (sample.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_time_ns (result.time_ns),
    .out_status  (result.status)
);
`default_nettype wire
